// ----- hw/rtl/scba_pkg.sv -----
// Shared types and codes for the size-class block allocator.
// No dependencies; used by every module of the block.
package scba_pkg;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_OUTSIDE   = 3'd3;
  localparam logic [2:0] ST_BAD_HDR   = 3'd4;

  // configuration register indexes
  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_LEN  = 1'b1;

  localparam int unsigned LOG_W  = 6;   // log2 of block size, 4..32
  localparam int unsigned CLS_W  = 5;   // class number, up to 31 by width
  localparam int unsigned GRAN_W = 20;  // granule index for the largest arena

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned LEN_CFG_W = 21;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [1:0]        mode;
    logic              too_large;
    logic [LOG_W-1:0]  size_log;
    logic [CLS_W-1:0]  cls;
    logic              outside;
    logic              bad_hdr;
    logic [GRAN_W-1:0] gran;
  } item_t;

endpackage

// ----- hw/rtl/scba_front.sv -----
// Front end: classifies one request (size class, free address checks).
// Depends on scba_pkg.
module scba_front #(
  parameter int unsigned ARENA_BYTES  = 1048576,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned NUM_CLASSES  = 10,
  parameter int unsigned OFF_W        = $clog2(ARENA_BYTES) + 1
) (
  input  logic [1:0]               mode_i,
  input  logic [63:0]              request_bytes_i,
  input  logic [63:0]              free_address_i,
  input  logic [scba_pkg::ADDR_W-1:0] arena_base_i,
  input  logic [OFF_W-1:0]         arena_len_i,
  output scba_pkg::item_t          item_o
);

  localparam int unsigned HDR = (HEADER_BYTES + 15) / 16 * 16;
  localparam int unsigned G_W = $clog2(ARENA_BYTES / 16);

  logic [31:0] req_m1;
  logic [5:0]  msb;
  logic [5:0]  lg;
  logic [5:0]  cls_raw;
  logic [63:0] rel;
  logic [63:0] hoff;

  always_comb begin
    req_m1 = request_bytes_i[31:0] - 32'd1;
    msb = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (req_m1[i]) msb = 6'(i);
    end
    lg = (request_bytes_i[31:0] <= 32'd16) ? 6'd4 : msb + 6'd1;
    cls_raw = lg - 6'd3;
  end

  assign rel  = free_address_i - {16'd0, arena_base_i};
  assign hoff = rel - 64'(HDR);

  always_comb begin
    item_o.mode      = mode_i;
    item_o.too_large = (request_bytes_i[63:32] != 32'd0);
    item_o.size_log  = lg;
    item_o.cls       = (cls_raw <= 6'(NUM_CLASSES)) ? scba_pkg::CLS_W'(cls_raw) : '0;
    item_o.outside   = (free_address_i < {16'd0, arena_base_i}) ||
                       (rel >= 64'(arena_len_i));
    item_o.bad_hdr   = (rel < 64'(HDR)) || (rel[3:0] != 4'd0);
    item_o.gran      = scba_pkg::GRAN_W'(G_W'(hoff >> 4));
  end

endmodule

// ----- hw/rtl/scba_queue.sv -----
// Two-entry queue of classified requests between front and back.
// Depends on scba_pkg.
module scba_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  scba_pkg::item_t item_i,
  input  logic            pop_i,
  output scba_pkg::item_t item_o,
  output logic            valid_o,
  output logic            full_o
);

  scba_pkg::item_t slot_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;

  assign item_o  = slot_q[rd_q];
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ----- hw/rtl/scba_back.sv -----
// Back end: class heads, bump pointer, granule header store and result beat.
// Depends on scba_pkg.
module scba_back #(
  parameter int unsigned ARENA_BYTES  = 1048576,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned NUM_CLASSES  = 10,
  parameter int unsigned OFF_W        = $clog2(ARENA_BYTES) + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [scba_pkg::ADDR_W-1:0] arena_base_i,
  input  logic [OFF_W-1:0]            arena_len_i,
  input  scba_pkg::item_t             item_i,
  input  logic                        item_valid_i,
  output logic                        pop_o,
  output logic                        clearing_o,
  output logic                        done_o,
  output logic [scba_pkg::ADDR_W-1:0] block_address_o,
  output logic [2:0]                  status_o,
  output logic                        reused_o
);

  localparam int unsigned HDR      = (HEADER_BYTES + 15) / 16 * 16;
  localparam int unsigned GRANULES = ARENA_BYTES / 16;
  localparam int unsigned G_W      = $clog2(GRANULES);
  localparam int unsigned CI_W     = $clog2(NUM_CLASSES + 1);
  localparam int unsigned EW       = 2 + CI_W + G_W;
  localparam int unsigned E_W      = OFF_W + 2;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [EW-1:0]  mem_q [GRANULES];
  logic [EW-1:0]  rd_q;
  logic [G_W-1:0] ra, wa;
  logic [EW-1:0]  wd;
  logic           we;

  logic [G_W-1:0]   clr_q;
  logic [OFF_W-1:0] bump_q, bump_d;
  logic             hv_q   [NUM_CLASSES + 1];
  logic [G_W-1:0]   head_q [NUM_CLASSES + 1];

  scba_pkg::item_t op_q;
  logic            hit_q;
  logic [G_W-1:0]  g_q;

  logic [CI_W-1:0] ci_in, ci_op;
  logic            hit_d;

  logic            hd_we, hd_v, hd_clr;
  logic [G_W-1:0]  hd_g;

  logic [scba_pkg::ADDR_W-1:0] res_addr;
  logic [2:0]                  res_status;
  logic                        res_reused;

  logic              rd_mark;
  logic [CI_W-1:0]   rd_cls;
  logic [E_W-1:0]    end_off;

  assign ci_in = CI_W'(item_i.cls);
  assign ci_op = CI_W'(op_q.cls);
  assign rd_mark = rd_q[EW-1];
  assign rd_cls  = rd_q[EW-2 -: CI_W];

  assign clearing_o = (state_q == S_CLEAR);
  assign pop_o      = (state_q == S_IDLE) && item_valid_i;
  assign hit_d      = (item_i.mode == scba_pkg::MODE_ALLOC) && !item_i.too_large &&
                      (item_i.cls != '0) && hv_q[ci_in];
  assign ra         = hit_d ? head_q[ci_in] : G_W'(item_i.gran);
  assign end_off    = E_W'(bump_q) + E_W'(HDR) + (E_W'(1) << op_q.size_log);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == G_W'(GRANULES - 1)) state_d = S_IDLE;
      S_IDLE:  if (item_valid_i) state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Execute the held request against the header read last cycle, or clear a header while clearing.
  always_comb begin
    we = 1'b0;
    wa = clr_q;
    wd = '0;
    bump_d = bump_q;
    hd_we = 1'b0;
    hd_v = 1'b0;
    hd_g = '0;
    hd_clr = 1'b0;
    res_addr = '0;
    res_status = scba_pkg::ST_OK;
    res_reused = 1'b0;
    if (state_q == S_CLEAR) begin
      we = 1'b1;
    end else if (state_q == S_EXEC) begin
      case (op_q.mode)
        scba_pkg::MODE_ALLOC: begin
          if (op_q.too_large) begin
            res_status = scba_pkg::ST_TOO_LARGE;
          end else if (hit_q) begin
            hd_we = 1'b1;
            hd_v = rd_q[G_W];
            hd_g = rd_q[G_W-1:0];
            res_addr = arena_base_i + scba_pkg::ADDR_W'({g_q, 4'd0}) +
                       scba_pkg::ADDR_W'(HDR);
            res_reused = 1'b1;
          end else if ((op_q.size_log >= scba_pkg::LOG_W'(OFF_W)) ||
                       (end_off >= E_W'(arena_len_i))) begin
            res_status = scba_pkg::ST_OVERFLOW;
          end else begin
            we = 1'b1;
            wa = G_W'(bump_q >> 4);
            wd = {1'b1, ci_op, 1'b0, {G_W{1'b0}}};
            bump_d = OFF_W'(end_off);
            res_addr = arena_base_i + scba_pkg::ADDR_W'(bump_q) + scba_pkg::ADDR_W'(HDR);
          end
        end
        scba_pkg::MODE_FREE: begin
          if (op_q.outside) begin
            res_status = scba_pkg::ST_OUTSIDE;
          end else if (op_q.bad_hdr || !rd_mark) begin
            res_status = scba_pkg::ST_BAD_HDR;
          end else if ((rd_cls != '0) && (rd_cls <= CI_W'(NUM_CLASSES))) begin
            we = 1'b1;
            wa = g_q;
            wd = {1'b1, rd_cls, hv_q[rd_cls], head_q[rd_cls]};
            hd_we = 1'b1;
            hd_v = 1'b1;
            hd_g = g_q;
          end
        end
        scba_pkg::MODE_RESET: begin
          bump_d = '0;
          hd_clr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q  <= item_i;
      hit_q <= hit_d;
      g_q   <= ra;
    end
    if (state_q == S_EXEC) begin
      block_address_o <= res_addr;
      status_o        <= res_status;
      reused_o        <= res_reused;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      bump_q  <= '0;
      done_o  <= 1'b0;
      for (int i = 0; i <= NUM_CLASSES; i++) begin
        hv_q[i]   <= 1'b0;
        head_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == S_EXEC);
      bump_q  <= bump_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + G_W'(1);
      if (hd_clr) begin
        for (int i = 0; i <= NUM_CLASSES; i++) hv_q[i] <= 1'b0;
      end else if (hd_we) begin
        // pop takes the old head's class, push the freed block's class
        if (op_q.mode == scba_pkg::MODE_FREE) begin
          hv_q[rd_cls]   <= hd_v;
          head_q[rd_cls] <= hd_g;
        end else begin
          hv_q[ci_op]   <= hd_v;
          head_q[ci_op] <= hd_g;
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_EXEC))
    else $error("result beat without an executed request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !pop_o)
    else $error("request taken during header clearing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) && hit_q |-> (op_q.mode == scba_pkg::MODE_ALLOC))
    else $error("list pop on a non-allocate request");

endmodule

// ----- hw/rtl/size_class_block_allocator.sv -----
// Top level of the size-class block allocator: config registers, front, queue, back.
// Depends on scba_pkg, scba_front, scba_queue and scba_back.
//
// After reset the block clears its granule header store, one granule a cycle, with busy
// high. Then the front classifies one request a cycle while busy is low into a two-entry
// queue, and the back takes each in turn: it reads the header store, then writes it,
// updates the class heads and registers the result. The back takes no new request until
// the last one is through. Each result is shown on done_o for one cycle and cannot be
// held off.
module size_class_block_allocator #(
  parameter int unsigned ARENA_BYTES  = 1048576,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned NUM_CLASSES  = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [63:0] request_bytes_i,
  input  logic [63:0] free_address_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [47:0] cfg_wdata_i,
  output logic        done_o,
  output logic [47:0] block_address_o,
  output logic [2:0]  status_o,
  output logic        reused_o
);

  localparam int unsigned OFF_W = $clog2(ARENA_BYTES) + 1;
  localparam int unsigned LEN_W = (OFF_W > scba_pkg::LEN_CFG_W) ? OFF_W : scba_pkg::LEN_CFG_W;

  logic [47:0]                      arena_base_q;
  logic [scba_pkg::LEN_CFG_W-1:0]   arena_bytes_q;
  logic [LEN_W-1:0]                 ab_ext;
  logic [OFF_W-1:0]                 arena_len;

  scba_pkg::item_t fr_item, q_item;
  logic            q_valid, q_full, pop, clearing, push;

  assign ab_ext    = LEN_W'(arena_bytes_q);
  assign arena_len = (ab_ext < LEN_W'(ARENA_BYTES)) ? OFF_W'(ab_ext) : OFF_W'(ARENA_BYTES);
  assign busy      = clearing || q_full;
  assign push      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_base_q  <= '0;
      arena_bytes_q <= scba_pkg::LEN_CFG_W'(1048576);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == scba_pkg::CFG_BASE) arena_base_q <= cfg_wdata_i;
      if (cfg_idx_i == scba_pkg::CFG_LEN) arena_bytes_q <= cfg_wdata_i[scba_pkg::LEN_CFG_W-1:0];
    end
  end

  scba_front #(
    .ARENA_BYTES(ARENA_BYTES), .HEADER_BYTES(HEADER_BYTES),
    .NUM_CLASSES(NUM_CLASSES), .OFF_W(OFF_W)
  ) u_front (
    .mode_i(mode_i), .request_bytes_i(request_bytes_i), .free_address_i(free_address_i),
    .arena_base_i(arena_base_q), .arena_len_i(arena_len), .item_o(fr_item)
  );

  scba_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .item_i(fr_item), .pop_i(pop),
    .item_o(q_item), .valid_o(q_valid), .full_o(q_full)
  );

  scba_back #(
    .ARENA_BYTES(ARENA_BYTES), .HEADER_BYTES(HEADER_BYTES),
    .NUM_CLASSES(NUM_CLASSES), .OFF_W(OFF_W)
  ) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .arena_base_i(arena_base_q), .arena_len_i(arena_len),
    .item_i(q_item), .item_valid_i(q_valid), .pop_o(pop), .clearing_o(clearing),
    .done_o(done_o), .block_address_o(block_address_o), .status_o(status_o),
    .reused_o(reused_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> busy)
    else $error("busy low during header clearing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != scba_pkg::ST_OK) |-> (block_address_o == '0) && !reused_o)
    else $error("refused request carries an address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("queue overrun");

endmodule
